// ===== rtl/fdr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_pkg
// Types and constants shared by the dielectric Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

   localparam int IDX_W  = 16;   // Q4.12 index
   localparam int COS_W  = 15;   // clamped cosine magnitude, Q.14
   localparam int RAD_W  = 60;   // radicand of the square root
   localparam int RT_W   = 30;   // root width
   localparam int REM_W  = 32;   // square-root remainder width
   localparam int PRD_W  = 30;   // eta*cos products, Q.26
   localparam int RAT_W  = 17;   // ratio, Q.16
   localparam int REFL_W = 17;   // reflectance, Q1.16

   localparam logic [COS_W-1:0]  COS_ONE  = 15'd16384;
   localparam logic [28:0]       ONE_Q28  = 29'h1000_0000;
   localparam logic [9:0]        VANISH   = 10'd671;
   localparam logic [REFL_W-1:0] REFL_ONE = 17'd65536;

   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [COS_W-1:0] c;
      logic             tir;
   } sq_tag_type;

   typedef struct packed {
      logic [PRD_W-1:0] p;
      logic [PRD_W-1:0] q;
      logic [RT_W-1:0]  e;
      logic             tir;
      logic             vanish;
   } kd_tag_type;

   typedef struct packed {
      logic tir;
      logic vanish;
      logic dz;
   } rt_tag_type;

endpackage
`default_nettype wire

// ===== rtl/fdr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fdr_div #(
   parameter int N_W   = 46,
   parameter int D_W   = 16,
   parameter int Q_W   = 30,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [N_W-1:0]   num,
   input  logic [D_W-1:0]   den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   quo,
   output logic [TAG_W-1:0] out_tag
);

   logic             vld_ff [Q_W];
   logic [N_W-1:0]   n_ff   [Q_W];
   logic [D_W-1:0]   d_ff   [Q_W];
   logic [D_W-1:0]   rem_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];
   logic [TAG_W-1:0] tag_ff [Q_W];
   logic [N_W-1:0]   n_top;

   // upper dividend bits seed the remainder; caller guarantees they are below den
   assign n_top = num >> Q_W;

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic             vld_prev;
      logic [N_W-1:0]   n_prev;
      logic [D_W-1:0]   d_prev;
      logic [D_W-1:0]   rem_prev;
      logic [Q_W-1:0]   quo_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [D_W:0]     trial;
      logic             fit;
      logic [D_W-1:0]   rem_in;
      logic [Q_W-1:0]   quo_in;

      if (s == 0) begin : g_first
         assign vld_prev = in_valid;
         assign n_prev   = num;
         assign d_prev   = den;
         assign rem_prev = n_top[D_W-1:0];
         assign quo_prev = '0;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[s-1];
         assign n_prev   = n_ff[s-1];
         assign d_prev   = d_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign quo_prev = quo_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      assign trial  = {rem_prev, n_prev[Q_W-1-s]};
      assign fit    = trial >= {1'b0, d_prev};
      assign rem_in = fit ? D_W'(trial - {1'b0, d_prev}) : trial[D_W-1:0];
      assign quo_in = {quo_prev[Q_W-2:0], fit};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[s]   <= n_prev;
            d_ff[s]   <= d_prev;
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
            tag_ff[s] <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign quo       = quo_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];

endmodule
`default_nettype wire

// ===== rtl/fdr_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fdr_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [fdr_pkg::RAD_W-1:0] rad,
   input  fdr_pkg::sq_tag_type     in_tag,
   output logic                    out_valid,
   output logic [fdr_pkg::RT_W-1:0]  root,
   output fdr_pkg::sq_tag_type     out_tag
);
   import fdr_pkg::*;

   logic             vld_ff  [RT_W];
   logic [RAD_W-1:0] rad_ff  [RT_W];
   logic [REM_W-1:0] rem_ff  [RT_W];
   logic [RT_W-1:0]  root_ff [RT_W];
   sq_tag_type       tag_ff  [RT_W];

   for (genvar s = 0; s < RT_W; s++) begin : g_stage
      logic             vld_prev;
      logic [RAD_W-1:0] rad_prev;
      logic [REM_W-1:0] rem_prev;
      logic [RT_W-1:0]  root_prev;
      sq_tag_type       tag_prev;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] test;
      logic             fit;
      logic [REM_W-1:0] rem_in;
      logic [RT_W-1:0]  root_in;

      if (s == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rad_prev  = rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign tag_prev  = in_tag;
      end else begin : g_next
         assign vld_prev  = vld_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign tag_prev  = tag_ff[s-1];
      end

      // bring down the next pair of radicand bits, try root*4+1
      assign trial   = {rem_prev, rad_prev[2*(RT_W-1-s)+1 -: 2]};
      assign test    = (REM_W+2)'({root_prev, 2'b01});
      assign fit     = trial >= test;
      assign rem_in  = fit ? REM_W'(trial - test) : trial[REM_W-1:0];
      assign root_in = {root_prev[RT_W-2:0], fit};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_prev;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            tag_ff[s]  <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[RT_W-1];
   assign root      = root_ff[RT_W-1];
   assign out_tag   = tag_ff[RT_W-1];

endmodule
`default_nettype wire

// ===== rtl/fresnel_dielectric_reflectance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized dielectric Fresnel reflectance in fixed point.
// ----------------------------------------------------------------------------
// Takes one item per cycle while no waiting result stalls it. The depth is
// set by the 30-stage square root, the 30-stage divider that forms eta_o*cos_t
// and the two 17-stage dividers for the amplitude ratios, each stage settling
// one bit. The whole pipeline advances together: while a result sits on the
// rsp_ side with rsp_stall high, every stage holds and req_stall is raised,
// so nothing is dropped or repeated. Bubbles travel as cleared valid bits.
// Indices of zero count as one LSB; cosine magnitudes above one are clamped.
// Total internal reflection gives 65536 with rsp_total_internal set; a
// vanishing cosine sum gives 0.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [15:0]                   req_index_outside,
   input  logic [15:0]                   req_index_inside,
   input  logic signed [15:0]            req_cosine_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fdr_pkg::REFL_W-1:0]    rsp_reflectance,
   output logic                          rsp_total_internal
);
   import fdr_pkg::*;

   logic en;

   // hold every stage while the output item waits
   assign en        = ~(rsp_valid && rsp_stall);
   assign req_stall = ~en;

   // ---- stage 1: zero-index fix, cosine magnitude and clamp ----
   logic [15:0]      mag;
   logic [IDX_W-1:0] a1_in, b1_in, a1_ff, b1_ff;
   logic [COS_W-1:0] c1_in, c1_ff;
   logic             v1_ff;

   assign mag   = req_cosine_in[15] ? $unsigned(-req_cosine_in) : $unsigned(req_cosine_in);
   assign a1_in = (req_index_outside == '0) ? 16'd1 : req_index_outside;
   assign b1_in = (req_index_inside == '0) ? 16'd1 : req_index_inside;
   assign c1_in = (mag > 16'(COS_ONE)) ? COS_ONE : mag[COS_W-1:0];

   // ---- stage 2: squares ----
   logic [31:0]      a2p_in, b2p_in, a2p2_ff, b2p2_ff;
   logic [28:0]      csq_in, csq2_ff;
   logic [IDX_W-1:0] a2_ff, b2_ff;
   logic [COS_W-1:0] c2_ff;
   logic             v2_ff;

   assign a2p_in = 32'(a1_ff) * 32'(a1_ff);
   assign b2p_in = 32'(b1_ff) * 32'(b1_ff);
   assign csq_in = 29'(c1_ff) * 29'(c1_ff);

   // ---- stage 3: sin^2 in Q.28 ----
   logic [28:0]      s2_in, s2_3_ff;
   logic [31:0]      a2p3_ff, b2p3_ff;
   logic [IDX_W-1:0] a3_ff, b3_ff;
   logic [COS_W-1:0] c3_ff;
   logic             v3_ff;

   assign s2_in = ONE_Q28 - csq2_ff;

   // ---- stage 4: eta_o^2 * sin^2 against eta_i^2 ----
   logic [60:0]      lhs_in, lhs4_ff;
   logic [59:0]      rhs_in, rhs4_ff;
   logic [IDX_W-1:0] a4_ff, b4_ff;
   logic [COS_W-1:0] c4_ff;
   logic             v4_ff;

   assign lhs_in = 61'(a2p3_ff) * 61'(s2_3_ff);
   assign rhs_in = {b2p3_ff, 28'd0};

   // ---- stage 5: total internal reflection test, radicand ----
   logic             tir_in;
   logic [RAD_W-1:0] rad_in, rad5_ff;
   sq_tag_type       t5_in, t5_ff;
   logic             v5_ff;

   assign tir_in = lhs4_ff > 61'(rhs4_ff);
   assign rad_in = tir_in ? '0 : RAD_W'(rhs4_ff - lhs4_ff[59:0]);
   assign t5_in  = '{a: a4_ff, b: b4_ff, c: c4_ff, tir: tir_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         c1_ff   <= c1_in;
         a2p2_ff <= a2p_in;
         b2p2_ff <= b2p_in;
         csq2_ff <= csq_in;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
         s2_3_ff <= s2_in;
         a2p3_ff <= a2p2_ff;
         b2p3_ff <= b2p2_ff;
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         c3_ff   <= c2_ff;
         lhs4_ff <= lhs_in;
         rhs4_ff <= rhs_in;
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         c4_ff   <= c3_ff;
         rad5_ff <= rad_in;
         t5_ff   <= t5_in;
      end
   end

   // ---- square root: E = eta_i * cos_t ----
   logic             vs;
   logic [RT_W-1:0]  es;
   sq_tag_type       ts;

   fdr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .rad       (rad5_ff),
      .in_tag    (t5_ff),
      .out_valid (vs),
      .root      (es),
      .out_tag   (ts)
   );

   // ---- stage 6: products and vanishing-sum test ----
   // the sum of cosines falls below 1e-5 only at zero incident cosine
   logic [45:0]      ae_in, ae6_ff;
   logic             van_in;
   kd_tag_type       t6_in, t6_ff;
   logic [IDX_W-1:0] b6_ff;
   logic             v6_ff;

   assign ae_in  = 46'(ts.a) * 46'(es);
   assign van_in = (ts.c == '0) && ({es, 12'd0} < 42'(VANISH) * 42'(ts.b));
   assign t6_in  = '{p: PRD_W'(ts.b) * PRD_W'(ts.c), q: PRD_W'(ts.a) * PRD_W'(ts.c),
                     e: es, tir: ts.tir, vanish: van_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= vs;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ae6_ff <= ae_in;
         b6_ff  <= ts.b;
         t6_ff  <= t6_in;
      end
   end

   // ---- divider: K = eta_o * E / eta_i ----
   logic             vk;
   logic [PRD_W-1:0] kq;
   logic [$bits(kd_tag_type)-1:0] tk_raw;
   kd_tag_type       tk;

   fdr_div #(.N_W(46), .D_W(IDX_W), .Q_W(PRD_W), .TAG_W($bits(kd_tag_type))) u_div_k (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .num       (ae6_ff),
      .den       (b6_ff),
      .in_tag    (t6_ff),
      .out_valid (vk),
      .quo       (kq),
      .out_tag   (tk_raw)
   );

   assign tk = tk_raw;

   // ---- stage 7: differences and sums for both ratios ----
   logic [PRD_W-1:0] np_in, nq_in, np7_ff, nq7_ff;
   logic [PRD_W:0]   dp_in, dq_in, dp7_ff, dq7_ff;
   logic             tir7_ff, van7_ff, v7_ff;

   assign np_in = (tk.p >= kq) ? tk.p - kq : kq - tk.p;
   assign dp_in = (PRD_W+1)'(tk.p) + (PRD_W+1)'(kq);
   assign nq_in = (tk.q >= tk.e) ? tk.q - tk.e : tk.e - tk.q;
   assign dq_in = (PRD_W+1)'(tk.q) + (PRD_W+1)'(tk.e);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= vk;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         np7_ff  <= np_in;
         dp7_ff  <= dp_in;
         nq7_ff  <= nq_in;
         dq7_ff  <= dq_in;
         tir7_ff <= tk.tir;
         van7_ff <= tk.vanish;
      end
   end

   // ---- ratio dividers: |x-y| * 2^16 / (x+y) ----
   rt_tag_type       trp_in, trp;
   logic [2:0]       trp_raw;
   logic             vr, vq, tq;
   logic [RAT_W-1:0] qpar, qperp;

   assign trp_in = '{tir: tir7_ff, vanish: van7_ff, dz: dp7_ff == '0};

   fdr_div #(.N_W(46), .D_W(PRD_W+1), .Q_W(RAT_W), .TAG_W(3)) u_div_par (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .num       ({np7_ff, 16'd0}),
      .den       (dp7_ff),
      .in_tag    (trp_in),
      .out_valid (vr),
      .quo       (qpar),
      .out_tag   (trp_raw)
   );

   assign trp = trp_raw;

   fdr_div #(.N_W(46), .D_W(PRD_W+1), .Q_W(RAT_W), .TAG_W(1)) u_div_perp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .num       ({nq7_ff, 16'd0}),
      .den       (dq7_ff),
      .in_tag    (dq7_ff == '0),
      .out_valid (vq),
      .quo       (qperp),
      .out_tag   (tq)
   );

   // ---- stage 8: squared ratios, a zero denominator counts as zero ----
   logic [33:0] sqp_in, sqq_in, sqp8_ff, sqq8_ff;
   logic        tir8_ff, van8_ff, v8_ff;

   assign sqp_in = trp.dz ? '0 : 34'(qpar) * 34'(qpar);
   assign sqq_in = tq ? '0 : 34'(qperp) * 34'(qperp);

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= vr && vq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqp8_ff <= sqp_in;
         sqq8_ff <= sqq_in;
         tir8_ff <= trp.tir;
         van8_ff <= trp.vanish;
      end
   end

   // ---- output stage: mean with rounding, saturate, special cases ----
   logic [34:0]       sum;
   logic [17:0]       half;
   logic [REFL_W-1:0] refl_in, refl_ff;
   logic              ti_in, ti_ff, rsp_valid_ff;

   assign sum  = 35'(sqp8_ff) + 35'(sqq8_ff) + 35'(REFL_ONE);
   assign half = sum[34:17];

   always_comb begin
      refl_in = (half > 18'(REFL_ONE)) ? REFL_ONE : half[REFL_W-1:0];
      ti_in   = 1'b0;
      if (tir8_ff) begin
         refl_in = REFL_ONE;
         ti_in   = 1'b1;
      end else if (van8_ff) begin
         refl_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff <= refl_in;
         ti_ff   <= ti_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reflectance    = refl_ff;
   assign rsp_total_internal = ti_ff;

endmodule
`default_nettype wire

// ===== rtl/fdr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_checker
// Port-level checks for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
module fdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_reflectance,
   input logic        rsp_total_internal
);

   // no item may come out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reflectance)
                                  && $stable(rsp_total_internal))
      else $error("stalled result changed");

   // a blocked output freezes the intake too
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   // reflectance never exceeds one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= 17'd65536)
      else $error("reflectance above one");

   // total internal reflection always reports full reflectance
   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == 17'd65536)
      else $error("total internal reflection without full reflectance");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_reflectance    (rsp_reflectance),
   .rsp_total_internal (rsp_total_internal)
);
`default_nettype wire
